// ===== rtl/gss_pkg.sv =====
// Shared types, codes and helpers for the positioning session sequencer.
`timescale 1ns / 1ps

package gss_pkg;

	localparam int TIMER_BITS = 16;
	localparam int REG_BITS   = 16;
	localparam int IDX_BITS   = 2;

	typedef logic [TIMER_BITS-1:0] timer_t;
	typedef logic [REG_BITS-1:0]   reg_t;

	// Configuration register indexes
	localparam logic [IDX_BITS-1:0] REG_RETRY   = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_QUERY   = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_SESSION = 2'd2;

	localparam reg_t RETRY_RESET   = 16'd51;
	localparam reg_t QUERY_RESET   = 16'd301;
	localparam reg_t SESSION_RESET = 16'd6001;

	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_STEP   = 3'd1,
		OP_RESULT = 3'd2,
		OP_REPORT = 3'd3,
		OP_FIX    = 3'd4,
		OP_MODE   = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_GET   = 3'd1,
		CMD_START = 3'd2,
		CMD_QUERY = 3'd3,
		CMD_STOP  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_OFF       = 2'd0,
		MODE_ON        = 2'd1,
		MODE_UNTIL_FIX = 2'd2,
		MODE_UNKNOWN   = 2'd3
	} mode_t;

	typedef enum logic [7:0] {
		ST_INIT     = 8'b0000_0001,
		ST_GET      = 8'b0000_0010,
		ST_STARTING = 8'b0000_0100,
		ST_STARTED  = 8'b0000_1000,
		ST_QUERY    = 8'b0001_0000,
		ST_STOPPING = 8'b0010_0000,
		ST_STOPPED  = 8'b0100_0000,
		ST_WAITRESP = 8'b1000_0000
	} seq_state_t;

	// Reported state codes
	localparam logic [2:0] SC_INIT     = 3'd0;
	localparam logic [2:0] SC_GET      = 3'd1;
	localparam logic [2:0] SC_STARTING = 3'd2;
	localparam logic [2:0] SC_STARTED  = 3'd3;
	localparam logic [2:0] SC_QUERY    = 3'd4;
	localparam logic [2:0] SC_STOPPING = 3'd5;
	localparam logic [2:0] SC_STOPPED  = 3'd6;
	localparam logic [2:0] SC_WAITRESP = 3'd7;

	typedef struct packed {
		reg_t retry_ticks;
		reg_t query_ticks;
		reg_t session_ticks;
	} gss_cfg_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic       cmd_accepted;
		logic       cmd_ok;
		logic       report_valid;
		logic       session_on;
		logic [1:0] mode_value;
	} gss_evt_t;

	typedef struct packed {
		logic [2:0] seq_state;
		logic [2:0] command_issued;
		logic       session_flag;
		logic       fix_flag;
		logic [1:0] mode_now;
	} gss_res_t;

	function automatic logic [2:0] state_code(seq_state_t s);
		logic [2:0] c;
		case (s)
			ST_INIT:     c = SC_INIT;
			ST_GET:      c = SC_GET;
			ST_STARTING: c = SC_STARTING;
			ST_STARTED:  c = SC_STARTED;
			ST_QUERY:    c = SC_QUERY;
			ST_STOPPING: c = SC_STOPPING;
			ST_STOPPED:  c = SC_STOPPED;
			ST_WAITRESP: c = SC_WAITRESP;
			default:     c = SC_INIT;
		endcase
		return c;
	endfunction

	function automatic timer_t to_timer(reg_t v);
		return TIMER_BITS'(v);
	endfunction

endpackage

// ===== rtl/gss_if.sv =====
// Valid/ready channel interfaces for events and results.
`timescale 1ns / 1ps

interface gss_evt_if;
	logic       valid;
	logic       ready;
	logic [2:0] opcode;
	logic       cmd_accepted;
	logic       cmd_ok;
	logic       report_valid;
	logic       session_on;
	logic [1:0] mode_value;

	modport source (
		output valid, opcode, cmd_accepted, cmd_ok, report_valid, session_on, mode_value,
		input  ready
	);
	modport sink (
		input  valid, opcode, cmd_accepted, cmd_ok, report_valid, session_on, mode_value,
		output ready
	);
endinterface

interface gss_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] seq_state;
	logic [2:0] command_issued;
	logic       session_flag;
	logic       fix_flag;
	logic [1:0] mode_now;

	modport source (
		output valid, seq_state, command_issued, session_flag, fix_flag, mode_now,
		input  ready
	);
	modport sink (
		input  valid, seq_state, command_issued, session_flag, fix_flag, mode_now,
		output ready
	);
endinterface

// ===== rtl/gss_cfg.sv =====
// Configuration register file for the retry, query and session times.
`timescale 1ns / 1ps

module gss_cfg
	import gss_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                we,
	input  logic [IDX_BITS-1:0] index,
	input  reg_t                data,
	output gss_cfg_t            cfg
);

	reg_t retry_q, query_q, session_q;
	reg_t wval;

	// A zero time is stored as immediate expiry
	assign wval = (data == '0) ? reg_t'(1) : data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_q   <= RETRY_RESET;
			query_q   <= QUERY_RESET;
			session_q <= SESSION_RESET;
		end else if (we) begin
			case (index)
				REG_RETRY:   retry_q   <= wval;
				REG_QUERY:   query_q   <= wval;
				REG_SESSION: session_q <= wval;
				default: ;
			endcase
		end
	end

	assign cfg.retry_ticks   = retry_q;
	assign cfg.query_ticks   = query_q;
	assign cfg.session_ticks = session_q;

endmodule

// ===== rtl/gss_seq.sv =====
// Session state, timers and next-state logic; yields one result per event.
`timescale 1ns / 1ps

module gss_seq
	import gss_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     take,
	input  gss_evt_t evt,
	input  gss_cfg_t cfg,
	output gss_res_t res
);

	localparam timer_t T_ONE = TIMER_BITS'(1);

	seq_state_t cur_q, saved_q, cur_d, saved_d;
	logic       wait_q, wait_d;
	timer_t     wtmr_q, wtmr_d, stmr_q, stmr_d;
	mode_t      mode_q, mode_d;
	logic       fix_q, fix_d;
	logic       active_q, active_d;
	cmd_t       cmd;

	always_comb begin
		cur_d    = cur_q;
		saved_d  = saved_q;
		wait_d   = wait_q;
		wtmr_d   = wtmr_q;
		stmr_d   = stmr_q;
		mode_d   = mode_q;
		fix_d    = fix_q;
		active_d = active_q;
		cmd      = CMD_NONE;
		case (evt.opcode)
			OP_TICK: begin
				if (wtmr_q > T_ONE) wtmr_d = wtmr_q - T_ONE;
				if (stmr_q > T_ONE) stmr_d = stmr_q - T_ONE;
			end
			OP_STEP: begin
				if (wait_q) begin
					if (wtmr_q == T_ONE) begin
						wait_d = 1'b0;
						wtmr_d = '0;
					end
				end else begin
					case (cur_q)
						ST_INIT: cur_d = ST_GET;
						ST_GET, ST_STARTING, ST_QUERY, ST_STOPPING: begin
							if (evt.cmd_accepted) begin
								saved_d = cur_q;
								cur_d   = ST_WAITRESP;
								case (cur_q)
									ST_GET:      cmd = CMD_GET;
									ST_STARTING: cmd = CMD_START;
									ST_QUERY:    cmd = CMD_QUERY;
									default:     cmd = CMD_STOP;
								endcase
							end
						end
						ST_STARTED: begin
							case (mode_q)
								MODE_OFF: cur_d = ST_STOPPING;
								MODE_ON: begin
									wait_d = 1'b1;
									wtmr_d = to_timer(cfg.query_ticks);
									cur_d  = ST_QUERY;
								end
								MODE_UNTIL_FIX: begin
									if (fix_q) begin
										mode_d = MODE_OFF;
										cur_d  = ST_STOPPING;
									end else if (stmr_q == T_ONE) begin
										stmr_d = '0;
										mode_d = MODE_OFF;
										cur_d  = ST_STOPPING;
									end else begin
										wait_d = 1'b1;
										wtmr_d = to_timer(cfg.query_ticks);
										cur_d  = ST_QUERY;
									end
								end
								default: ;
							endcase
						end
						ST_STOPPED: begin
							if (mode_q == MODE_ON || mode_q == MODE_UNTIL_FIX) begin
								fix_d = 1'b0;
								cur_d = ST_STARTING;
							end
						end
						default: ;
					endcase
				end
			end
			OP_RESULT: begin
				if (evt.cmd_ok) begin
					if (saved_q == ST_STARTING) begin
						stmr_d = to_timer(cfg.session_ticks);
						cur_d  = ST_STARTED;
					end else if (saved_q == ST_QUERY) begin
						cur_d = ST_STARTED;
					end
				end else begin
					// Retry the state that issued the failed command
					wait_d = 1'b1;
					wtmr_d = to_timer(cfg.retry_ticks);
					cur_d  = saved_q;
				end
			end
			OP_REPORT: begin
				if (evt.report_valid) begin
					if (evt.session_on) begin
						active_d = 1'b1;
						stmr_d   = to_timer(cfg.session_ticks);
						cur_d    = ST_STARTED;
					end else begin
						active_d = 1'b0;
						cur_d    = ST_STOPPED;
					end
				end
			end
			OP_FIX:  fix_d = 1'b1;
			OP_MODE: mode_d = mode_t'(evt.mode_value);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= ST_INIT;
			saved_q  <= ST_INIT;
			wait_q   <= 1'b0;
			wtmr_q   <= '0;
			stmr_q   <= '0;
			mode_q   <= MODE_OFF;
			fix_q    <= 1'b0;
			active_q <= 1'b0;
		end else if (take) begin
			cur_q    <= cur_d;
			saved_q  <= saved_d;
			wait_q   <= wait_d;
			wtmr_q   <= wtmr_d;
			stmr_q   <= stmr_d;
			mode_q   <= mode_d;
			fix_q    <= fix_d;
			active_q <= active_d;
		end
	end

	assign res.seq_state      = state_code(cur_d);
	assign res.command_issued = cmd;
	assign res.session_flag   = active_d;
	assign res.fix_flag       = fix_d;
	assign res.mode_now       = mode_d;

endmodule

// ===== rtl/gss_out.sv =====
// Result register that drives the result channel.
`timescale 1ns / 1ps

module gss_out
	import gss_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  gss_res_t res_d,
	input  logic     ready,
	output logic     valid,
	output gss_res_t res
);

	logic     valid_q;
	gss_res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_q <= res_d;
	end

	assign valid = valid_q;
	assign res   = res_q;

endmodule

// ===== rtl/gnss_session_sequencer_core.sv =====
// Top level of the positioning session sequencer.
`timescale 1ns / 1ps
//
// Events enter on evt (valid/ready): ticks, task steps, command results,
// session reports, fixes and mode writes. Every event gives exactly one
// result on res (valid/ready): reported state, command issued, session and
// fix flags, and the mode.
// The next-state logic updates the state registers and loads the result
// register at the edge that accepts the event.
// Throughput is one event per cycle while results are taken, set by the
// single register stage; evt.ready is high whenever the result register
// is empty or being taken. When the receiver stalls, the result holds and
// evt.ready drops until it is taken.
// Configuration (cfg_we, cfg_index, cfg_data) writes the retry, query and
// session times; a zero is stored as one. Write only while idle.
// Reset clears the state, timers, mode and flags, restores the default
// times and empties the result register.

module gnss_session_sequencer_core
	import gss_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	gss_evt_if.sink             evt,
	gss_res_if.source           res,
	input  logic                cfg_we,
	input  logic [IDX_BITS-1:0] cfg_index,
	input  reg_t                cfg_data
);

	gss_cfg_t cfg;
	gss_evt_t evt_p;
	gss_res_t res_d, res_p;
	logic     take;

	assign evt.ready = !res.valid || res.ready;
	assign take      = evt.valid && evt.ready;

	assign evt_p.opcode       = evt.opcode;
	assign evt_p.cmd_accepted = evt.cmd_accepted;
	assign evt_p.cmd_ok       = evt.cmd_ok;
	assign evt_p.report_valid = evt.report_valid;
	assign evt_p.session_on   = evt.session_on;
	assign evt_p.mode_value   = evt.mode_value;

	gss_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	gss_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.evt    (evt_p),
		.cfg    (cfg),
		.res    (res_d)
	);

	gss_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (take),
		.res_d  (res_d),
		.ready  (res.ready),
		.valid  (res.valid),
		.res    (res_p)
	);

	assign res.seq_state      = res_p.seq_state;
	assign res.command_issued = res_p.command_issued;
	assign res.session_flag   = res_p.session_flag;
	assign res.fix_flag       = res_p.fix_flag;
	assign res.mode_now       = res_p.mode_now;

	// An accepted event always shows up as a result next cycle
	a_take_res: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> res.valid)
		else $error("accepted event produced no result");

	// An empty result register never blocks requests
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res.valid |-> evt.ready)
		else $error("input stalled with empty result register");

	// An issued command leaves the sequencer waiting for its response
	a_cmd_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.command_issued != CMD_NONE) |-> res.seq_state == SC_WAITRESP)
		else $error("command issued without waiting for response");

	// Only a task step issues a command
	a_cmd_step: assert property (@(posedge clk) disable iff (!arst_n)
		(take && evt.opcode != OP_STEP) |=> res.command_issued == CMD_NONE)
		else $error("command issued on an event other than a task step");

endmodule
